// File: hdl/elhc_pkg.sv
`default_nettype none
package elhc_pkg;

  localparam int MAX_FRAME_DEF = 65535;

  localparam logic [15:0] ETH_VLAN  = 16'h8100;
  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [15:0] ETH_IPV6  = 16'h86DD;
  localparam logic [15:0] FRAG_MASK = 16'h1FFF;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [15:0] PORT_DNS      = 16'd53;
  localparam logic [15:0] PORT_HTTP     = 16'd80;
  localparam logic [15:0] PORT_HTTP_ALT = 16'd8080;
  localparam logic [15:0] PORT_TLS      = 16'd443;
  localparam logic [15:0] PORT_TLS_ALT  = 16'd8443;

  localparam logic [2:0] IP_V4 = 3'd4;
  localparam logic [2:0] IP_V6 = 3'd6;
  localparam logic [2:0] IP_NONE = 3'd0;

  localparam logic LINK_ETH = 1'b0;
  localparam logic LINK_RAW = 1'b1;

  localparam logic REG_LINK_TYPE = 1'b0;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_NOT_IP    = 3'd2,
    ST_BAD_IP    = 3'd3,
    ST_FRAGMENT  = 3'd4,
    ST_TRANSPORT = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    APP_NONE = 2'd0,
    APP_DNS  = 2'd1,
    APP_HTTP = 2'd2,
    APP_TLS  = 2'd3
  } app_t;

  // header fields gathered while a frame streams in
  typedef struct packed {
    logic [15:0] et1;
    logic [15:0] et2;
    logic [7:0]  ipb0;
    logic [7:0]  ip6;
    logic [7:0]  ip7;
    logic [7:0]  ip9;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [7:0]  thb;
    logic [15:0] len;
    logic        oversize;
  } fields_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  ip_version;
    logic [7:0]  protocol;
    logic [31:0] ipv4_source;
    logic [31:0] ipv4_destination;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
    logic        payload_present;
    logic [1:0]  app_class;
  } result_t;

endpackage
`default_nettype wire

// File: hdl/elhc_capture.sv
`default_nettype none
module elhc_capture
  import elhc_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       link_type,
  input  wire logic       accept,
  input  wire logic [7:0] frame_byte,
  input  wire logic       last_byte,
  output fields_t         fields_next
);

  localparam int PosW = $clog2(MAX_FRAME + 1);

  logic [PosW-1:0] pos;
  fields_t         cap;
  logic            near;
  logic [6:0]      p7;
  logic            vlan_tag;
  logic            is_v4;
  logic [6:0]      ip_off;
  logic [6:0]      ihl;
  logic [6:0]      t;
  logic [6:0]      rel_ip;
  logic [6:0]      rel_t;

  always_comb begin
    fields_next = cap;
    near     = (32'(pos) < 32'd128);
    p7       = pos[6:0];
    vlan_tag = (cap.et1 == ETH_VLAN);
    if (link_type == LINK_RAW) begin
      ip_off = 7'd0;
      is_v4  = (cap.ipb0[7:4] == 4'd4);
    end else begin
      ip_off = vlan_tag ? 7'd18 : 7'd14;
      is_v4  = ((vlan_tag ? cap.et2 : cap.et1) == ETH_IPV4);
    end
    ihl    = {1'b0, cap.ipb0[3:0], 2'b00};
    t      = ip_off + (is_v4 ? ihl : 7'd40);
    rel_ip = p7 - ip_off;
    rel_t  = p7 - t;
    if (near) begin
      case (p7)
        7'd12: fields_next.et1[15:8] = frame_byte;
        7'd13: fields_next.et1[7:0]  = frame_byte;
        7'd16: fields_next.et2[15:8] = frame_byte;
        7'd17: fields_next.et2[7:0]  = frame_byte;
        default: ;
      endcase
      case (rel_ip)
        7'd0:  fields_next.ipb0 = frame_byte;
        7'd6:  fields_next.ip6  = frame_byte;
        7'd7:  fields_next.ip7  = frame_byte;
        7'd9:  fields_next.ip9  = frame_byte;
        7'd12: fields_next.src[31:24] = frame_byte;
        7'd13: fields_next.src[23:16] = frame_byte;
        7'd14: fields_next.src[15:8]  = frame_byte;
        7'd15: fields_next.src[7:0]   = frame_byte;
        7'd16: fields_next.dst[31:24] = frame_byte;
        7'd17: fields_next.dst[23:16] = frame_byte;
        7'd18: fields_next.dst[15:8]  = frame_byte;
        7'd19: fields_next.dst[7:0]   = frame_byte;
        default: ;
      endcase
      case (rel_t)
        7'd0:  fields_next.sp[15:8] = frame_byte;
        7'd1:  fields_next.sp[7:0]  = frame_byte;
        7'd2:  fields_next.dp[15:8] = frame_byte;
        7'd3:  fields_next.dp[7:0]  = frame_byte;
        7'd12: fields_next.thb      = frame_byte;
        default: ;
      endcase
    end
    fields_next.len      = 16'(pos) + 16'd1;
    fields_next.oversize = (pos == PosW'(MAX_FRAME));
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cap <= fields_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      if (last_byte) begin
        pos <= '0;
      end else if (pos != PosW'(MAX_FRAME)) begin
        pos <= pos + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/elhc_classify.sv
`default_nettype none
module elhc_classify
  import elhc_pkg::*;
(
  input  wire logic link_type,
  input  fields_t   fields,
  output result_t   result
);

  logic        ok;
  logic        vlan;
  logic [15:0] et;
  logic [15:0] ip_off;
  logic [15:0] ip_len;
  logic [15:0] ihl;
  logic [15:0] t;
  logic [15:0] tlen;
  logic [15:0] thl;

  always_comb begin
    result = '0;
    ok     = 1'b1;
    vlan   = 1'b0;
    et     = '0;
    ip_off = '0;
    ip_len = '0;
    ihl    = '0;
    t      = '0;
    tlen   = '0;
    thl    = '0;

    if (fields.oversize) begin
      result.status = ST_TRANSPORT;
      ok = 1'b0;
    end else if (link_type == LINK_ETH) begin
      if (fields.len < 16'd14) begin
        result.status = ST_SHORT;
        ok = 1'b0;
      end else begin
        vlan   = (fields.et1 == ETH_VLAN) && (fields.len >= 16'd18);
        et     = vlan ? fields.et2 : fields.et1;
        ip_off = vlan ? 16'd18 : 16'd14;
        if (et == ETH_IPV4) begin
          result.ip_version = IP_V4;
        end else if (et == ETH_IPV6) begin
          result.ip_version = IP_V6;
        end else begin
          result.status = ST_NOT_IP;
          ok = 1'b0;
        end
      end
    end else begin
      if (fields.ipb0[7:4] == 4'd4) begin
        result.ip_version = IP_V4;
      end else if (fields.ipb0[7:4] == 4'd6) begin
        result.ip_version = IP_V6;
      end else begin
        result.status = ST_NOT_IP;
        ok = 1'b0;
      end
    end

    if (ok) begin
      ip_len = fields.len - ip_off;
      if (result.ip_version == IP_V4) begin
        ihl = {10'd0, fields.ipb0[3:0], 2'b00};
        if (ip_len < 16'd20 || ihl < 16'd20 || ihl > ip_len) begin
          result.status = ST_BAD_IP;
          ok = 1'b0;
        end else begin
          result.ipv4_source      = fields.src;
          result.ipv4_destination = fields.dst;
          result.protocol         = fields.ip9;
          t    = ip_off + ihl;
          tlen = ip_len - ihl;
          if (({fields.ip6, fields.ip7} & FRAG_MASK) != 16'd0) begin
            result.status = ST_FRAGMENT;
            ok = 1'b0;
          end
        end
      end else begin
        if (ip_len < 16'd40) begin
          result.status = ST_BAD_IP;
          ok = 1'b0;
        end else begin
          result.protocol = fields.ip6;
          t    = ip_off + 16'd40;
          tlen = ip_len - 16'd40;
        end
      end
    end

    if (ok) begin
      if (result.protocol == PROTO_TCP && tlen >= 16'd20) begin
        result.source_port      = fields.sp;
        result.destination_port = fields.dp;
        thl = {10'd0, fields.thb[7:4], 2'b00};
        if (thl >= 16'd20 && thl <= tlen) begin
          result.payload_offset  = t + thl;
          result.payload_length  = tlen - thl;
          result.payload_present = (tlen != thl);
        end
      end else if (result.protocol == PROTO_UDP && tlen >= 16'd8) begin
        result.source_port      = fields.sp;
        result.destination_port = fields.dp;
        result.payload_offset   = t + 16'd8;
        result.payload_length   = tlen - 16'd8;
        result.payload_present  = (tlen != 16'd8);
      end else begin
        result.status = ST_TRANSPORT;
      end
    end

    if (result.payload_present) begin
      if (fields.dp == PORT_DNS || fields.sp == PORT_DNS) begin
        result.app_class = APP_DNS;
      end else if (fields.dp == PORT_HTTP || fields.dp == PORT_HTTP_ALT ||
                   fields.sp == PORT_HTTP) begin
        result.app_class = APP_HTTP;
      end else if (fields.dp == PORT_TLS || fields.dp == PORT_TLS_ALT) begin
        result.app_class = APP_TLS;
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/ethernet_ip_l4_header_classifier.sv
`default_nettype none
// Frame header classifier. Frames enter one byte per transaction (last_byte
// marks the end) and each frame yields one result transaction. A byte is
// taken every cycle while frame_ready is high; header fields are picked off
// as they stream past, so no header buffer is kept. The result passes through
// a field snapshot register, then the result register, and is held back only
// by result_ready. link_type (offset 0x0) selects Ethernet with optional
// 802.1Q tag (0) or raw IP (1); change it only while no frame is in flight.
module ethernet_ip_l4_header_classifier
  import elhc_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,

  input  wire logic        frame_valid,
  output logic             frame_ready,
  input  wire logic [7:0]  frame_byte,
  input  wire logic        last_byte,

  output logic             result_valid,
  input  wire logic        result_ready,
  output logic [2:0]       status,
  output logic [2:0]       ip_version,
  output logic [7:0]       protocol,
  output logic [31:0]      ipv4_source,
  output logic [31:0]      ipv4_destination,
  output logic [15:0]      source_port,
  output logic [15:0]      destination_port,
  output logic [15:0]      payload_offset,
  output logic [15:0]      payload_length,
  output logic             payload_present,
  output logic [1:0]       app_class
);

  logic    link_type;
  logic    accept;
  logic    snap_valid;
  logic    snap_free;
  logic    out_free;
  fields_t fields_next;
  fields_t snap;
  result_t result_next;
  result_t result;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_type <= LINK_ETH;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_LINK_TYPE) begin
      link_type <= pwdata[0];
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LINK_TYPE: prdata = {31'd0, link_type};
      default:       prdata = '0;
    endcase
  end

  assign out_free    = !result_valid || result_ready;
  assign snap_free   = !snap_valid || out_free;
  assign frame_ready = snap_free;
  assign accept      = frame_valid && frame_ready;

  elhc_capture #(
    .MAX_FRAME(MAX_FRAME)
  ) u_capture (
    .clk        (clk),
    .rst        (rst),
    .link_type  (link_type),
    .accept     (accept),
    .frame_byte (frame_byte),
    .last_byte  (last_byte),
    .fields_next(fields_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (snap_free) begin
      snap_valid <= accept && last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      snap <= fields_next;
    end
  end

  elhc_classify u_classify (
    .link_type(link_type),
    .fields   (snap),
    .result   (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && snap_valid) begin
      result <= result_next;
    end
  end

  assign status           = result.status;
  assign ip_version       = result.ip_version;
  assign protocol         = result.protocol;
  assign ipv4_source      = result.ipv4_source;
  assign ipv4_destination = result.ipv4_destination;
  assign source_port      = result.source_port;
  assign destination_port = result.destination_port;
  assign payload_offset   = result.payload_offset;
  assign payload_length   = result.payload_length;
  assign payload_present  = result.payload_present;
  assign app_class        = result.app_class;

  a_ok_has_version: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_OK |-> ip_version == IP_V4 || ip_version == IP_V6)
    else $error("ok result without IP version");

  a_payload_consistent: assert property (@(posedge clk) disable iff (rst)
    result_valid && payload_present |-> status == ST_OK && payload_length != 16'd0)
    else $error("payload flag inconsistent with status or length");

  a_app_needs_payload: assert property (@(posedge clk) disable iff (rst)
    result_valid && app_class != APP_NONE |-> payload_present)
    else $error("application class without payload");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !frame_ready |-> snap_valid && result_valid && !result_ready)
    else $error("input stalled with room in the pipeline");

endmodule
`default_nettype wire

// File: tb/sv/tb_ethernet_ip_l4_header_classifier.sv
`timescale 1ns / 1ps

import elhc_pkg::*;

localparam int unsigned HEADER_KEEP = 128;
localparam logic [16:0] POSITION_TOP = 17'h1FFFF;

class frame_verdict_board;
  logic              link_raw;
  logic [16:0]       position;
  logic [7:0]        head [HEADER_KEEP];
  result_t           pending_verdicts[$];
  int unsigned       mismatches;

  function new();
    link_raw = LINK_ETH;
    position = '0;
    mismatches = 0;
    foreach (head[i]) head[i] = 8'h00;
  endfunction

  function int unsigned hdr8(int unsigned idx);
    return (idx < HEADER_KEEP) ? int'(head[idx]) : 0;
  endfunction

  function int unsigned hdr16(int unsigned idx);
    return (hdr8(idx) << 8) | hdr8(idx + 1);
  endfunction

  function int unsigned hdr32(int unsigned idx);
    return (hdr16(idx) << 16) | hdr16(idx + 2);
  endfunction

  function result_t classify(int unsigned len);
    result_t     r;
    int unsigned ip_off, ip_len, ihl, t, tlen, thl, et, sp, dp, plen;
    logic [3:0]  nib;
    r = '0;
    t = 0;
    tlen = 0;
    if (len > MAX_FRAME_DEF) begin
      r.status = ST_TRANSPORT;
      return r;
    end
    if (link_raw == LINK_ETH) begin
      if (len < 14) begin
        r.status = ST_SHORT;
        return r;
      end
      et = hdr16(12);
      if (et == ETH_VLAN && len >= 18) begin
        et = hdr16(16);
        ip_off = 18;
      end else begin
        ip_off = 14;
      end
      if (et == ETH_IPV4) r.ip_version = IP_V4;
      else if (et == ETH_IPV6) r.ip_version = IP_V6;
      else begin
        r.status = ST_NOT_IP;
        return r;
      end
    end else begin
      nib = 4'(hdr8(0) >> 4);
      ip_off = 0;
      if (nib == 4'(IP_V4)) r.ip_version = IP_V4;
      else if (nib == 4'(IP_V6)) r.ip_version = IP_V6;
      else begin
        r.status = ST_NOT_IP;
        return r;
      end
    end
    ip_len = len - ip_off;

    if (r.ip_version == IP_V4) begin
      if (ip_len < 20) begin
        r.status = ST_BAD_IP;
        return r;
      end
      ihl = (hdr8(ip_off) & 4'hF) * 4;
      if (ihl < 20 || ihl > ip_len) begin
        r.status = ST_BAD_IP;
        return r;
      end
      r.ipv4_source = hdr32(ip_off + 12);
      r.ipv4_destination = hdr32(ip_off + 16);
      r.protocol = 8'(hdr8(ip_off + 9));
      t = ip_off + ihl;
      tlen = ip_len - ihl;
      if ((hdr16(ip_off + 6) & FRAG_MASK) != 0) begin
        r.status = ST_FRAGMENT;
        return r;
      end
    end else begin
      if (ip_len < 40) begin
        r.status = ST_BAD_IP;
        return r;
      end
      r.protocol = 8'(hdr8(ip_off + 6));
      t = ip_off + 40;
      tlen = ip_len - 40;
    end

    plen = 0;
    if (r.protocol == PROTO_TCP && tlen >= 20) begin
      sp = hdr16(t);
      dp = hdr16(t + 2);
      thl = ((hdr8(t + 12) >> 4) & 4'hF) * 4;
      if (thl >= 20 && thl <= tlen) begin
        r.payload_offset = 16'(t + thl);
        plen = tlen - thl;
      end
    end else if (r.protocol == PROTO_UDP && tlen >= 8) begin
      sp = hdr16(t);
      dp = hdr16(t + 2);
      r.payload_offset = 16'(t + 8);
      plen = tlen - 8;
    end else begin
      r.status = ST_TRANSPORT;
      return r;
    end
    r.source_port = 16'(sp);
    r.destination_port = 16'(dp);
    r.payload_length = 16'(plen);
    r.payload_present = (plen > 0);

    if (r.payload_present) begin
      if (dp == PORT_DNS || sp == PORT_DNS) r.app_class = APP_DNS;
      else if (dp == PORT_HTTP || dp == PORT_HTTP_ALT || sp == PORT_HTTP)
        r.app_class = APP_HTTP;
      else if (dp == PORT_TLS || dp == PORT_TLS_ALT) r.app_class = APP_TLS;
    end
    r.status = ST_OK;
    return r;
  endfunction

  function void note_byte(logic [7:0] b, logic is_last);
    if (position < HEADER_KEEP) head[position] = b;
    if (!is_last) begin
      if (position != POSITION_TOP) position++;
    end else begin
      pending_verdicts.push_back(classify(32'(position) + 1));
      position = '0;
    end
  endfunction

  function void flag(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch: expected %0h got %0h", $realtime, what, want, got);
  endfunction

  function void compare(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) flag(what, want, got);
  endfunction

  function void check_verdict(result_t got);
    result_t want;
    if (pending_verdicts.size() == 0) begin
      flag("unexpected result transaction", 0, 0);
      return;
    end
    want = pending_verdicts.pop_front();
    compare("status", 32'(want.status), 32'(got.status));
    compare("ip_version", 32'(want.ip_version), 32'(got.ip_version));
    compare("protocol", 32'(want.protocol), 32'(got.protocol));
    compare("ipv4_source", want.ipv4_source, got.ipv4_source);
    compare("ipv4_destination", want.ipv4_destination, got.ipv4_destination);
    compare("source_port", 32'(want.source_port), 32'(got.source_port));
    compare("destination_port", 32'(want.destination_port), 32'(got.destination_port));
    compare("payload_offset", 32'(want.payload_offset), 32'(got.payload_offset));
    compare("payload_length", 32'(want.payload_length), 32'(got.payload_length));
    compare("payload_present", 32'(want.payload_present), 32'(got.payload_present));
    compare("app_class", 32'(want.app_class), 32'(got.app_class));
  endfunction
endclass

module tb_ethernet_ip_l4_header_classifier;

  localparam logic [2:0]  ADDR_LINK_TYPE = {REG_LINK_TYPE, 2'b00};
  localparam logic [2:0]  ADDR_NO_REG    = 3'd4;
  localparam logic [15:0] ETH_OTHER      = 16'h88CC;
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam int          CYCLE_LIMIT    = 2000000;
  localparam int          HOLD_CYCLES    = 600;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        frame_valid = 1'b0;
  logic        frame_ready;
  logic [7:0]  frame_byte = '0;
  logic        last_byte = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [2:0]  status;
  logic [2:0]  ip_version;
  logic [7:0]  protocol;
  logic [31:0] ipv4_source;
  logic [31:0] ipv4_destination;
  logic [15:0] source_port;
  logic [15:0] destination_port;
  logic [15:0] payload_offset;
  logic [15:0] payload_length;
  logic        payload_present;
  logic [1:0]  app_class;

  frame_verdict_board sb = new();

  logic [7:0] frame_hdr[$];
  bit         gaps_on = 1'b1;
  bit         hold_req = 1'b0;
  int         burst_left = 0;
  int         cycle_count = 0;

  ethernet_ip_l4_header_classifier u_top (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .frame_valid      (frame_valid),
    .frame_ready      (frame_ready),
    .frame_byte       (frame_byte),
    .last_byte        (last_byte),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .status           (status),
    .ip_version       (ip_version),
    .protocol         (protocol),
    .ipv4_source      (ipv4_source),
    .ipv4_destination (ipv4_destination),
    .source_port      (source_port),
    .destination_port (destination_port),
    .payload_offset   (payload_offset),
    .payload_length   (payload_length),
    .payload_present  (payload_present),
    .app_class        (app_class)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void put8(logic [7:0] b);
    frame_hdr.push_back(b);
  endfunction

  function automatic void put16(logic [15:0] v);
    put8(v[15:8]);
    put8(v[7:0]);
  endfunction

  function automatic void put_random(int n);
    repeat (n) put8(8'($urandom));
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 9))
      0: return PORT_DNS;
      1: return PORT_HTTP;
      2: return PORT_HTTP_ALT;
      3: return PORT_TLS;
      4: return PORT_TLS_ALT;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void add_eth(logic vlan, logic [15:0] etype);
    put_random(12);
    if (vlan) begin
      put16(ETH_VLAN);
      put16(16'($urandom));
    end
    put16(etype);
  endfunction

  function automatic void add_ipv4(int ihl_words, logic [12:0] frag, logic [7:0] proto);
    put8({4'(IP_V4), 4'(ihl_words)});
    put_random(5);
    put16({3'($urandom), frag});
    put8(8'($urandom));
    put8(proto);
    put_random(10);
    if (ihl_words > 5) put_random((ihl_words - 5) * 4);
  endfunction

  function automatic void add_ipv6(logic [7:0] proto);
    put8({4'(IP_V6), 4'($urandom)});
    put_random(5);
    put8(proto);
    put_random(33);
  endfunction

  function automatic void add_tcp(logic [15:0] sp, logic [15:0] dp, logic [3:0] off);
    put16(sp);
    put16(dp);
    put_random(8);
    put8({off, 4'($urandom)});
    put_random(7);
    if (off > 5) put_random((int'(off) - 5) * 4);
  endfunction

  function automatic void add_udp(logic [15:0] sp, logic [15:0] dp);
    put16(sp);
    put16(dp);
    put_random(4);
  endfunction

  // entered and left at a falling edge
  task automatic drive_byte(input logic [7:0] b, input logic is_last);
    if (gaps_on && burst_left == 0) begin
      frame_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    if (burst_left > 0) burst_left--;
    frame_valid <= 1'b1;
    frame_byte <= b;
    last_byte <= is_last;
    forever begin
      @(posedge clk);
      if (frame_ready) break;
    end
    sb.note_byte(b, is_last);
    @(negedge clk);
  endtask

  // bytes past the built header are random payload
  task automatic send_frame(input int unsigned total);
    logic [7:0] b;
    for (int unsigned i = 0; i < total; i++) begin
      b = (i < frame_hdr.size()) ? frame_hdr[i] : 8'($urandom);
      drive_byte(b, i == total - 1);
    end
    frame_hdr.delete();
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    if (addr == ADDR_LINK_TYPE) sb.link_raw = data[0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    frame_valid <= 1'b0;
    while (sb.pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_frame();
    int          kind, ihl, plen, total, pick;
    logic        v6;
    logic [7:0]  proto;
    logic [15:0] etype;
    kind = $urandom_range(0, 99);
    gaps_on = ($urandom_range(0, 4) != 0);
    if (kind < 10) begin
      send_frame($urandom_range(1, 80));
      return;
    end
    v6 = ($urandom_range(0, 2) == 0);
    if (sb.link_raw == LINK_ETH) begin
      etype = v6 ? ETH_IPV6 : ETH_IPV4;
      if ($urandom_range(0, 19) == 0) etype = 16'($urandom);
      add_eth($urandom_range(0, 3) == 0, etype);
    end
    pick = $urandom_range(0, 99);
    proto = (pick < 45) ? PROTO_TCP : (pick < 90) ? PROTO_UDP : 8'($urandom);
    if (v6) begin
      add_ipv6(proto);
    end else begin
      ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
      add_ipv4(ihl, ($urandom_range(0, 7) == 0) ? 13'($urandom) : 13'd0, proto);
    end
    if (proto == PROTO_TCP) begin
      add_tcp(pick_port(), pick_port(),
              ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(5, 8)));
    end else if (proto == PROTO_UDP) begin
      add_udp(pick_port(), pick_port());
    end else begin
      put_random($urandom_range(0, 24));
    end
    plen = ($urandom_range(0, 15) == 0) ? $urandom_range(41, 400) : $urandom_range(0, 24);
    total = frame_hdr.size() + plen;
    if (kind < 25) total = $urandom_range(1, frame_hdr.size());
    else if (kind < 30) frame_hdr[$urandom_range(0, frame_hdr.size() - 1)] = 8'($urandom);
    send_frame(total);
  endtask

  always @(posedge clk) begin
    result_t got;
    if (!rst && result_valid && result_ready) begin
      got.status = status;
      got.ip_version = ip_version;
      got.protocol = protocol;
      got.ipv4_source = ipv4_source;
      got.ipv4_destination = ipv4_destination;
      got.source_port = source_port;
      got.destination_port = destination_port;
      got.payload_offset = payload_offset;
      got.payload_length = payload_length;
      got.payload_present = payload_present;
      got.app_class = app_class;
      sb.check_verdict(got);
    end
  end

  // result side: stall patterns, plus one long hold-off on request
  initial begin
    int mode, span, tick;
    tick = 0;
    wait (rst == 1'b0);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(negedge clk);
        if (hold_req) begin
          result_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_req = 1'b0;
        end
        tick++;
        case (mode)
          0: result_ready <= 1'b1;
          1: result_ready <= 1'($urandom_range(0, 1));
          2: result_ready <= ($urandom_range(0, 3) == 0);
          default: result_ready <= (tick % 3 != 0);
        endcase
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    apb_write(ADDR_LINK_TYPE, 32'(LINK_ETH));

    // Ethernet framing: short link, short IP, short VLAN tag, non-IP
    send_frame(1);
    send_frame(13);
    add_eth(1'b0, ETH_IPV4);
    send_frame(14);
    add_eth(1'b0, ETH_VLAN);
    send_frame(17);
    add_eth(1'b0, ETH_OTHER);
    send_frame(60);
    // tagged UDP DNS
    add_eth(1'b1, ETH_IPV4);
    add_ipv4(5, 13'd0, PROTO_UDP);
    add_udp(16'($urandom), PORT_DNS);
    send_frame(frame_hdr.size() + 12);
    // bad IHL: too small, then larger than the IP bytes present
    add_eth(1'b0, ETH_IPV4);
    add_ipv4(4, 13'd0, PROTO_TCP);
    send_frame(54);
    add_eth(1'b0, ETH_IPV4);
    add_ipv4(15, 13'd0, PROTO_TCP);
    send_frame(54);
    // later fragment, then a transport that is neither TCP nor UDP
    add_eth(1'b0, ETH_IPV4);
    add_ipv4(5, FRAG_MASK[12:0], PROTO_UDP);
    add_udp(pick_port(), pick_port());
    send_frame(frame_hdr.size() + 4);
    add_eth(1'b0, ETH_IPV4);
    add_ipv4(5, 13'd0, PROTO_ICMP);
    send_frame(70);
    // transport headers cut short
    add_eth(1'b0, ETH_IPV4);
    add_ipv4(5, 13'd0, PROTO_UDP);
    send_frame(41);
    add_eth(1'b0, ETH_IPV4);
    add_ipv4(5, 13'd0, PROTO_TCP);
    send_frame(53);
    // TCP data offset below minimum, then beyond the segment
    add_eth(1'b0, ETH_IPV4);
    add_ipv4(5, 13'd0, PROTO_TCP);
    add_tcp(PORT_HTTP, PORT_TLS, 4'd4);
    send_frame(frame_hdr.size() + 9);
    add_eth(1'b0, ETH_IPV4);
    add_ipv4(5, 13'd0, PROTO_TCP);
    add_tcp(PORT_HTTP, PORT_TLS, 4'd0);
    frame_hdr[46] = 8'hF0;
    send_frame(frame_hdr.size() + 10);
    // application classes, then an IPv6 header cut short
    add_eth(1'b0, ETH_IPV4);
    add_ipv4(6, 13'd0, PROTO_TCP);
    add_tcp(PORT_HTTP, 16'd40000, 4'd5);
    send_frame(frame_hdr.size() + 30);
    add_eth(1'b1, ETH_IPV4);
    add_ipv4(5, 13'd0, PROTO_TCP);
    add_tcp(16'd51000, PORT_HTTP_ALT, 4'd8);
    send_frame(frame_hdr.size() + 3);
    add_eth(1'b0, ETH_IPV6);
    add_ipv6(PROTO_TCP);
    add_tcp(16'd51001, PORT_TLS, 4'd5);
    send_frame(frame_hdr.size() + 5);
    add_eth(1'b0, ETH_IPV4);
    add_ipv4(5, 13'd0, PROTO_UDP);
    add_udp(16'd51002, PORT_TLS_ALT);
    send_frame(frame_hdr.size() + 1);
    add_eth(1'b0, ETH_IPV4);
    add_ipv4(5, 13'd0, PROTO_UDP);
    add_udp(PORT_DNS, PORT_DNS);
    send_frame(frame_hdr.size());
    add_eth(1'b0, ETH_IPV6);
    send_frame(53);
    // largest frame, then one byte over
    gaps_on = 1'b0;
    add_eth(1'b0, ETH_IPV4);
    add_ipv4(5, 13'd0, PROTO_UDP);
    add_udp(pick_port(), PORT_DNS);
    send_frame(MAX_FRAME_DEF);
    add_eth(1'b0, ETH_IPV4);
    add_ipv4(5, 13'd0, PROTO_UDP);
    add_udp(pick_port(), PORT_DNS);
    send_frame(MAX_FRAME_DEF + 1);
    gaps_on = 1'b1;
    wait_idle();

    apb_write(ADDR_NO_REG, 32'(LINK_RAW));
    apb_write(ADDR_LINK_TYPE, 32'(LINK_RAW));
    add_ipv4(5, 13'd0, PROTO_UDP);
    add_udp(PORT_DNS, 16'($urandom));
    send_frame(frame_hdr.size() + 7);
    put8(8'h55);
    send_frame(30);
    put8(8'h45);
    send_frame(1);
    add_ipv6(PROTO_UDP);
    add_udp(16'($urandom), PORT_HTTP_ALT);
    send_frame(frame_hdr.size() + 2);
    // byte counter runs into saturation
    gaps_on = 1'b0;
    add_ipv4(5, 13'd0, PROTO_TCP);
    add_tcp(pick_port(), pick_port(), 4'd5);
    send_frame(32'(POSITION_TOP) + 4);
    gaps_on = 1'b1;
    wait_idle();

    repeat (40) random_frame();
    wait_idle();
    apb_write(ADDR_LINK_TYPE, 32'(LINK_ETH));
    hold_req = 1'b1;
    repeat (60) random_frame();
    wait_idle();
    apb_write(ADDR_LINK_TYPE, 32'(LINK_RAW));
    repeat (40) random_frame();
    wait_idle();
    repeat (10) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/elhc_pkg.sv
hdl/elhc_capture.sv
hdl/elhc_classify.sv
hdl/ethernet_ip_l4_header_classifier.sv
tb/sv/tb_ethernet_ip_l4_header_classifier.sv
